FILE: rtl/ptl_pkg.sv
// ptl_pkg: shared types and constants for the postfix-to-load/op code block.
// Used by ptl_front, ptl_back, ptl_checker and the top level.
// No dependencies.
`default_nettype none

package ptl_pkg;

    // Default operand stack depth (entries of 8 bits).
    localparam int STACK_DEPTH_DEF = 64;

    // Depth of the queue between front and back; must be a power of two.
    localparam int QDEPTH = 2;

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Result kinds as they appear on the output channel.
    typedef enum logic [3:0] {
        KIND_LOAD    = 4'd0,
        KIND_ADD     = 4'd1,
        KIND_SUB     = 4'd2,
        KIND_MUL     = 4'd3,
        KIND_DIV     = 4'd4,
        KIND_STORE   = 4'd5,
        KIND_BADEXPR = 4'd6,
        KIND_BADIN   = 4'd7,
        KIND_END     = 4'd8,
        KIND_OVF     = 4'd9
    } kind_t;

    // Character class decided by the front end.
    typedef enum logic [1:0] {
        CLS_LETTER = 2'd0,
        CLS_OP     = 2'd1,
        CLS_BAD    = 2'd2,
        CLS_END    = 2'd3
    } cls_t;

    // One classified beat held in the queue.
    typedef struct packed {
        cls_t       cls;
        kind_t      op;
        logic [7:0] sym;
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/postfix_to_load_op_code.sv
// postfix_to_load_op_code: top level of the postfix-to-load/op/store code block.
// Instantiates ptl_front and ptl_back; depends on ptl_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat per postfix character,
//   symbol plus is_end. An end beat reports whether the operand stack is
//   empty and drops any deferred store.
//   Output channel (out_valid / out_stall): one beat per result, with kind,
//   operands, temp number, stack_empty and last (set on the final result
//   of each input beat). A letter without a deferred store, or any beat
//   after an error, shows nothing.
//   Path: an accepted beat is registered in the queue, each result in the
//   output register; an operator whose top operand is read back after an
//   end beat first fetches it in ST_RDTOP. Throughput: at most one result
//   per cycle while out_stall is low. The single registered read port of
//   the stack fetches an operator's operands one per cycle.
//   A two-beat queue lets the front keep taking beats while the back works
//   or out_stall holds the registered output beat; a full queue raises in_stall.
//   Reset: stack count, deferred store, temp counter and halt flag clear;
//   no clearing pass is run, the block takes beats right away.
`default_nettype none

module postfix_to_load_op_code #(
    parameter int STACK_DEPTH = ptl_pkg::STACK_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] symbol,
    input  wire logic       is_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [3:0]      kind,
    output logic [7:0]      first_operand,
    output logic [7:0]      second_operand,
    output logic [7:0]      temp_number,
    output logic            stack_empty,
    output logic            last
);

    logic           head_valid;
    ptl_pkg::item_t head_item;
    logic           head_pop;

    // front: classify characters and queue them
    ptl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .symbol     (symbol),
        .is_end     (is_end),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop)
    );

    // back: stack, deferred store, temp counter, result sequencing
    ptl_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .head_pop       (head_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .temp_number    (temp_number),
        .stack_empty    (stack_empty),
        .last           (last)
    );

endmodule

`default_nettype wire

FILE: rtl/ptl_front.sv
// ptl_front: accepts input beats, classifies the character and queues it.
// Depends on ptl_pkg.
`default_nettype none

module ptl_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    symbol,
    input  wire logic          is_end,
    output logic               head_valid,
    output ptl_pkg::item_t     head_item,
    input  wire logic          head_pop
);

    localparam int QPW = (ptl_pkg::QDEPTH > 1) ? $clog2(ptl_pkg::QDEPTH) : 1;
    localparam int QCW = $clog2(ptl_pkg::QDEPTH + 1);

    ptl_pkg::item_t q_mem_reg [ptl_pkg::QDEPTH];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] q_cnt_reg, q_cnt_next;
    ptl_pkg::item_t cls_item;
    logic           push;

    // Classify the incoming character.
    always_comb
    begin
        cls_item.sym = symbol;
        cls_item.op  = ptl_pkg::KIND_LOAD;
        if (is_end)
        begin
            cls_item.cls = ptl_pkg::CLS_END;
        end
        else if (symbol >= ptl_pkg::CH_A && symbol <= ptl_pkg::CH_Z)
        begin
            cls_item.cls = ptl_pkg::CLS_LETTER;
        end
        else
        begin
            cls_item.cls = ptl_pkg::CLS_OP;
            case (symbol)
                ptl_pkg::CH_PLUS:  cls_item.op = ptl_pkg::KIND_ADD;
                ptl_pkg::CH_MINUS: cls_item.op = ptl_pkg::KIND_SUB;
                ptl_pkg::CH_STAR:  cls_item.op = ptl_pkg::KIND_MUL;
                ptl_pkg::CH_SLASH: cls_item.op = ptl_pkg::KIND_DIV;
                default:           cls_item.cls = ptl_pkg::CLS_BAD;
            endcase
        end
    end

    assign in_stall   = (q_cnt_reg == QCW'(ptl_pkg::QDEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (q_cnt_reg != '0);
    assign head_item  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = head_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg + QCW'(push) - QCW'(head_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ptl_back.sv
// ptl_back: sequencer that runs queued beats against the operand stack
// and drives the registered output channel. Depends on ptl_pkg.
`default_nettype none

module ptl_back #(
    parameter int STACK_DEPTH = ptl_pkg::STACK_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire ptl_pkg::item_t head_item,
    output logic                head_pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [3:0]          kind,
    output logic [7:0]          first_operand,
    output logic [7:0]          second_operand,
    output logic [7:0]          temp_number,
    output logic                stack_empty,
    output logic                last
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [5:0] {
        ST_HEAD  = 6'b000001,
        ST_CHAR  = 6'b000010,
        ST_RDTOP = 6'b000100,
        ST_LOAD2 = 6'b001000,
        ST_OP    = 6'b010000,
        ST_OVF   = 6'b100000
    } state_t;

    // Stack memory
    logic [7:0]    mem [STACK_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    wr_data;

    state_t         state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]     top_reg, top_next;
    logic           top_ok_reg, top_ok_next;
    logic [7:0]     nxt_reg, nxt_next;
    logic           pend_reg, pend_next;
    logic [7:0]     pend_op_reg, pend_op_next;
    logic [7:0]     temp_reg, temp_next;
    logic           halt_reg, halt_next;

    logic           out_valid_reg;
    ptl_pkg::kind_t kind_reg;
    logic [7:0]     first_reg, second_reg, tnum_reg;
    logic           empty_reg, last_reg;

    logic           adv, do_emit, char_step;
    ptl_pkg::kind_t e_kind;
    logic [7:0]     e_a, e_b, e_t;
    logic           e_empty, e_last;
    logic           full, below_two;

    assign adv       = !out_valid_reg || !out_stall;
    assign full      = (count_reg == CNT_W'(STACK_DEPTH));
    assign below_two = (count_reg < CNT_W'(2));

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        top_ok_next  = top_ok_reg;
        nxt_next     = nxt_reg;
        pend_next    = pend_reg;
        pend_op_next = pend_op_reg;
        temp_next    = temp_reg;
        halt_next    = halt_reg;
        do_emit      = 1'b0;
        char_step    = 1'b0;
        e_kind       = ptl_pkg::KIND_LOAD;
        e_a          = '0;
        e_b          = '0;
        e_t          = '0;
        e_empty      = 1'b0;
        e_last       = 1'b0;
        head_pop     = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = AW'(count_reg);
        wr_data      = '0;

        if (adv)
        begin
            case (state_reg)
                ST_HEAD:
                begin
                    if (head_valid)
                    begin
                        if (halt_reg)
                        begin
                            head_pop = 1'b1;
                        end
                        else if (head_item.cls == ptl_pkg::CLS_END)
                        begin
                            do_emit   = 1'b1;
                            e_kind    = ptl_pkg::KIND_END;
                            e_empty   = (count_reg == '0);
                            e_last    = 1'b1;
                            pend_next = 1'b0;
                            head_pop  = 1'b1;
                        end
                        else if (pend_reg)
                        begin
                            // deferred store comes out before the character
                            do_emit   = 1'b1;
                            e_kind    = ptl_pkg::KIND_STORE;
                            e_a       = pend_op_reg;
                            e_t       = temp_reg;
                            pend_next = 1'b0;
                            if (full)
                            begin
                                state_next = ST_OVF;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                wr_data     = pend_op_reg;
                                count_next  = count_reg + 1'b1;
                                top_next    = pend_op_reg;
                                top_ok_next = 1'b1;
                                state_next  = ST_CHAR;
                                // a letter that still fits adds no result
                                e_last = (head_item.cls == ptl_pkg::CLS_LETTER) &&
                                         (count_reg < CNT_W'(STACK_DEPTH - 1));
                            end
                        end
                        else
                        begin
                            char_step = 1'b1;
                        end
                    end
                end
                ST_CHAR:
                begin
                    char_step = 1'b1;
                end
                ST_RDTOP:
                begin
                    do_emit     = 1'b1;
                    e_kind      = ptl_pkg::KIND_LOAD;
                    e_a         = rd_data_reg;
                    top_next    = rd_data_reg;
                    top_ok_next = 1'b1;
                    rd_en       = 1'b1;
                    rd_addr     = AW'(count_reg - CNT_W'(2));
                    state_next  = ST_LOAD2;
                end
                ST_LOAD2:
                begin
                    do_emit    = 1'b1;
                    e_kind     = ptl_pkg::KIND_LOAD;
                    e_a        = rd_data_reg;
                    nxt_next   = rd_data_reg;
                    state_next = ST_OP;
                end
                ST_OP:
                begin
                    do_emit      = 1'b1;
                    e_kind       = head_item.op;
                    e_a          = top_reg;
                    e_b          = nxt_reg;
                    e_last       = 1'b1;
                    count_next   = count_reg - CNT_W'(2);
                    top_ok_next  = 1'b0;
                    pend_next    = 1'b1;
                    pend_op_next = nxt_reg;
                    temp_next    = (temp_reg != 8'hFF) ? temp_reg + 8'd1 : temp_reg;
                    head_pop     = 1'b1;
                    state_next   = ST_HEAD;
                end
                ST_OVF:
                begin
                    do_emit    = 1'b1;
                    e_kind     = ptl_pkg::KIND_OVF;
                    e_last     = 1'b1;
                    halt_next  = 1'b1;
                    head_pop   = 1'b1;
                    state_next = ST_HEAD;
                end
                default:
                begin
                    state_next = ST_HEAD;
                end
            endcase

            if (char_step)
            begin
                case (head_item.cls)
                    ptl_pkg::CLS_LETTER:
                    begin
                        head_pop   = 1'b1;
                        state_next = ST_HEAD;
                        if (full)
                        begin
                            do_emit   = 1'b1;
                            e_kind    = ptl_pkg::KIND_OVF;
                            e_last    = 1'b1;
                            halt_next = 1'b1;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_data     = head_item.sym;
                            count_next  = count_reg + 1'b1;
                            top_next    = head_item.sym;
                            top_ok_next = 1'b1;
                        end
                    end
                    ptl_pkg::CLS_OP:
                    begin
                        if (below_two)
                        begin
                            do_emit    = 1'b1;
                            e_kind     = ptl_pkg::KIND_BADEXPR;
                            e_last     = 1'b1;
                            halt_next  = 1'b1;
                            head_pop   = 1'b1;
                            state_next = ST_HEAD;
                        end
                        else if (top_ok_reg)
                        begin
                            do_emit    = 1'b1;
                            e_kind     = ptl_pkg::KIND_LOAD;
                            e_a        = top_reg;
                            rd_en      = 1'b1;
                            rd_addr    = AW'(count_reg - CNT_W'(2));
                            state_next = ST_LOAD2;
                        end
                        else
                        begin
                            // top not cached after a dropped store: fetch it
                            rd_en      = 1'b1;
                            rd_addr    = AW'(count_reg - CNT_W'(1));
                            state_next = ST_RDTOP;
                        end
                    end
                    default:
                    begin
                        do_emit    = 1'b1;
                        e_kind     = ptl_pkg::KIND_BADIN;
                        e_last     = 1'b1;
                        halt_next  = 1'b1;
                        head_pop   = 1'b1;
                        state_next = ST_HEAD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (adv && do_emit)
        begin
            kind_reg   <= e_kind;
            first_reg  <= e_a;
            second_reg <= e_b;
            tnum_reg   <= e_t;
            empty_reg  <= e_empty;
            last_reg   <= e_last;
        end
        top_reg <= top_next;
        nxt_reg <= nxt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HEAD;
            count_reg     <= '0;
            top_ok_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            pend_op_reg   <= '0;
            temp_reg      <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            top_ok_reg  <= top_ok_next;
            pend_reg    <= pend_next;
            pend_op_reg <= pend_op_next;
            temp_reg    <= temp_next;
            halt_reg    <= halt_next;
            if (adv)
            begin
                out_valid_reg <= do_emit;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign first_operand  = first_reg;
    assign second_operand = second_reg;
    assign temp_number    = tnum_reg;
    assign stack_empty    = empty_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

FILE: rtl/ptl_checker.sv
// ptl_checker: port-level assertions for postfix_to_load_op_code, with bind.
// Depends on ptl_pkg.
`default_nettype none

module ptl_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [3:0] kind,
    input wire logic [7:0] first_operand,
    input wire logic [7:0] second_operand,
    input wire logic       stack_empty,
    input wire logic       last
);

    // stalled beat stays up
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(kind) && $stable(first_operand) &&
                                   $stable(second_operand) && $stable(last))
        else $error("output beat changed while stalled");

    // errors and end status always close out their input beat
    a_final_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == ptl_pkg::KIND_END || kind == ptl_pkg::KIND_BADEXPR ||
                      kind == ptl_pkg::KIND_BADIN || kind == ptl_pkg::KIND_OVF)
        |-> last)
        else $error("terminal result without last");

    a_empty_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stack_empty |-> kind == ptl_pkg::KIND_END)
        else $error("stack_empty on a non-end result");

    // a load is always followed by more results of the same beat
    a_load_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == ptl_pkg::KIND_LOAD |-> !last && second_operand == 8'd0)
        else $error("load marked last or carries a second operand");

endmodule

bind postfix_to_load_op_code ptl_checker u_ptl_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for postfix_to_load_op_code (postfix to load/op/store code).
// Needs ptl_pkg and the block's RTL only. A directed table runs first, then
// random well-formed postfix traffic, and the run closes with one fatal fault.

module tb_top;

    localparam int STACK_DEPTH  = ptl_pkg::STACK_DEPTH_DEF;
    localparam int RAND_BEATS   = 360;   // random beats before the closing fault
    localparam int PHASE_LEN    = 150;   // beats per idle pattern
    localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 16;    // idle cycles run after the last owed result
    localparam int DIR_ROWS     = 18;

    // One result beat as seen on the output channel.
    typedef struct packed {
        ptl_pkg::kind_t kind;
        logic [7:0]     first_op;
        logic [7:0]     second_op;
        logic [7:0]     tnum;
        logic           empty;
        logic           last;
    } code_t;

    // Directed row: either typed in (zero or one result) or left to the predictor.
    typedef struct packed {
        logic [7:0] sym;
        logic       end_flag;
        logic       typed;
        logic       has_code;
        code_t      code;
    } dir_row_t;

    typedef enum logic [1:0] {PH_SLOW_RX, PH_SLOW_TX, PH_FREE} gap_phase_t;
    typedef enum logic [1:0] {FAULT_OVF, FAULT_EXPR, FAULT_INPUT} fault_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] symbol;
    logic       is_end;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] kind;
    logic [7:0] first_operand;
    logic [7:0] second_operand;
    logic [7:0] temp_number;
    logic       stack_empty;
    logic       last;

    postfix_to_load_op_code #(.STACK_DEPTH(STACK_DEPTH)) uut (.*);

    // ------------------------------------------------------------------
    // Code generator predictor: own copy of the operand stack, the deferred
    // store and the temp counter. Results of one beat land in scratch[].
    // ------------------------------------------------------------------
    logic [7:0] stk [STACK_DEPTH];
    int         stk_cnt;
    int         stk_peak;
    bit         st_pending;
    logic [7:0] st_operand;
    logic [7:0] tmp_cnt;
    bit         is_halted;
    int         ops_done;
    int         ops_at_ceiling;

    code_t      scratch [4];
    int         scratch_n;
    code_t      code_due [$];    // results still owed by the block, oldest first

    int         err_cnt;
    int         beats_in;
    int         codes_seen;
    int         quiet_cycles;
    gap_phase_t idle_phase;
    fault_t     fault_hit;

    function automatic code_t mk_code(ptl_pkg::kind_t k, logic [7:0] a, logic [7:0] b,
                                      logic [7:0] t, logic e);
        code_t c;
        c.kind      = k;
        c.first_op  = a;
        c.second_op = b;
        c.tnum      = t;
        c.empty     = e;
        c.last      = 1'b0;
        return c;
    endfunction

    task automatic emit(input code_t c);
        scratch[scratch_n] = c;
        scratch_n++;
    endtask

    // A push into a full stack flags overflow and halts.
    task automatic stack_push(input logic [7:0] v, output bit ok);
        if (stk_cnt >= STACK_DEPTH)
        begin
            emit(mk_code(ptl_pkg::KIND_OVF, 8'd0, 8'd0, 8'd0, 1'b0));
            is_halted = 1'b1;
            ok = 1'b0;
        end
        else
        begin
            stk[stk_cnt] = v;
            stk_cnt++;
            if (stk_cnt > stk_peak)
                stk_peak = stk_cnt;
            ok = 1'b1;
        end
    endtask

    // Works out the codes one accepted beat produces. keep = 0 only advances
    // the state (the directed row supplies its own expectation).
    task automatic translate_symbol(input logic [7:0] sym, input logic end_flag,
                                    input bit keep);
        bit             ok;
        bit             is_op;
        ptl_pkg::kind_t op;
        logic [7:0]     top_v;
        logic [7:0]     next_v;
        int             i;
        scratch_n = 0;
        if (!is_halted)
        begin
            if (end_flag)
            begin
                // deferred store is dropped, stack and counter are kept
                st_pending = 1'b0;
                emit(mk_code(ptl_pkg::KIND_END, 8'd0, 8'd0, 8'd0, stk_cnt == 0));
            end
            else
            begin
                ok = 1'b1;
                if (st_pending)
                begin
                    st_pending = 1'b0;
                    emit(mk_code(ptl_pkg::KIND_STORE, st_operand, 8'd0, tmp_cnt, 1'b0));
                    stack_push(st_operand, ok);
                end
                if (ok)
                begin
                    is_op = 1'b1;
                    case (sym)
                        ptl_pkg::CH_PLUS:  op = ptl_pkg::KIND_ADD;
                        ptl_pkg::CH_MINUS: op = ptl_pkg::KIND_SUB;
                        ptl_pkg::CH_STAR:  op = ptl_pkg::KIND_MUL;
                        ptl_pkg::CH_SLASH: op = ptl_pkg::KIND_DIV;
                        default:
                        begin
                            op    = ptl_pkg::KIND_LOAD;
                            is_op = 1'b0;
                        end
                    endcase
                    if (sym >= ptl_pkg::CH_A && sym <= ptl_pkg::CH_Z)
                    begin
                        stack_push(sym, ok);
                    end
                    else if (is_op)
                    begin
                        if (stk_cnt < 2)
                        begin
                            emit(mk_code(ptl_pkg::KIND_BADEXPR, 8'd0, 8'd0, 8'd0, 1'b0));
                            is_halted = 1'b1;
                        end
                        else
                        begin
                            top_v  = stk[stk_cnt-1];
                            next_v = stk[stk_cnt-2];
                            stk_cnt -= 2;
                            emit(mk_code(ptl_pkg::KIND_LOAD, top_v, 8'd0, 8'd0, 1'b0));
                            emit(mk_code(ptl_pkg::KIND_LOAD, next_v, 8'd0, 8'd0, 1'b0));
                            emit(mk_code(op, top_v, next_v, 8'd0, 1'b0));
                            st_operand = next_v;
                            st_pending = 1'b1;
                            ops_done++;
                            if (tmp_cnt == 8'hFF)
                                ops_at_ceiling++;   // counter holds at the top
                            else
                                tmp_cnt++;
                        end
                    end
                    else
                    begin
                        emit(mk_code(ptl_pkg::KIND_BADIN, 8'd0, 8'd0, 8'd0, 1'b0));
                        is_halted = 1'b1;
                    end
                end
            end
        end
        if (scratch_n > 0)
            scratch[scratch_n-1].last = 1'b1;
        if (keep)
            for (i = 0; i < scratch_n; i++)
                code_due.push_back(scratch[i]);
    endtask

    // ------------------------------------------------------------------
    // Idle patterns: sender 37 / receiver 81, then swapped, then none.
    // ------------------------------------------------------------------
    function automatic int gap_pct(gap_phase_t ph, bit rx_side);
        case (ph)
            PH_SLOW_RX: return rx_side ? 81 : 37;
            PH_SLOW_TX: return rx_side ? 37 : 81;
            default:    return 0;
        endcase
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] v;
        v = 8'($urandom_range(25));
        return ptl_pkg::CH_A + v;
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(3))
            0:       return ptl_pkg::CH_PLUS;
            1:       return ptl_pkg::CH_MINUS;
            2:       return ptl_pkg::CH_STAR;
            default: return ptl_pkg::CH_SLASH;
        endcase
    endfunction

    function automatic dir_row_t pred_row(logic [7:0] s, logic e);
        dir_row_t r;
        r.sym      = s;
        r.end_flag = e;
        r.typed    = 1'b0;
        r.has_code = 1'b0;
        r.code     = '0;
        return r;
    endfunction

    function automatic dir_row_t typed_row(logic [7:0] s, logic e, logic has, code_t c);
        dir_row_t r;
        r.sym       = s;
        r.end_flag  = e;
        r.typed     = 1'b1;
        r.has_code  = has;
        r.code      = c;
        r.code.last = 1'b1;
        return r;
    endfunction

    // Drives one input beat, called at a rising edge. Sender gaps are drawn
    // per cycle; valid stays high across back-to-back beats. Returns at the
    // edge that accepted the beat, after the predictor has seen it.
    task automatic send_beat(input logic [7:0] sym, input logic end_flag, input bit keep);
        int pct;
        pct = gap_pct(idle_phase, 1'b0);
        while ($urandom_range(99) < pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= sym;
        is_end   <= end_flag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        translate_symbol(sym, end_flag, keep);
        beats_in++;
        if (beats_in == PHASE_LEN)
            idle_phase <= PH_SLOW_TX;
        else if (beats_in == 2 * PHASE_LEN)
            idle_phase <= PH_FREE;
    endtask

    // Closes the run with one halting fault (picked by the seed), then shows
    // the halted block a few more beats of every sort: none may give a code.
    task automatic finish_with_fault();
        logic [7:0] s;
        int         k;
        fault_hit = fault_t'($urandom_range(2));
        case (fault_hit)
            FAULT_OVF:
            begin
                send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
                while (stk_cnt < STACK_DEPTH)
                    send_beat(rand_letter(), 1'b0, 1'b1);
                send_beat(rand_letter(), 1'b0, 1'b1);
            end
            FAULT_EXPR:
            begin
                // reduce to one operand or none; a deferred store may still
                // be emitted ahead of the error
                while (stk_cnt + st_pending >= 2)
                    send_beat(rand_op(), 1'b0, 1'b1);
                if ($urandom_range(1))
                    send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
                send_beat(rand_op(), 1'b0, 1'b1);
            end
            default:
            begin
                do
                    s = 8'($urandom_range(255));
                while ((s >= ptl_pkg::CH_A && s <= ptl_pkg::CH_Z) ||
                       s == ptl_pkg::CH_PLUS || s == ptl_pkg::CH_MINUS ||
                       s == ptl_pkg::CH_STAR || s == ptl_pkg::CH_SLASH);
                send_beat(s, 1'b0, 1'b1);
            end
        endcase
        for (k = 0; k < 8; k++)
            case ($urandom_range(3))
                0:       send_beat(rand_letter(), 1'b0, 1'b1);
                1:       send_beat(rand_op(), 1'b0, 1'b1);
                2:       send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
                default: send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
            endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                      codes_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Clock, output stall and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(99) < gap_pct(idle_phase, 1'b1));
        end
    end

    // Any cycle with a beat on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles, %0d results still owed",
                     QUIET_LIMIT, code_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every accepted output beat against the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_mon
        code_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            codes_seen++;
            if (code_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %0d, kind %0d",
                                          codes_seen, kind));
            end
            else
            begin
                want = code_due.pop_front();
                check_field("kind", kind, want.kind);
                check_field("first_operand", first_operand, want.first_op);
                check_field("second_operand", second_operand, want.second_op);
                check_field("temp_number", temp_number, want.tnum);
                check_field("stack_empty", stack_empty, want.empty);
                check_field("last", last, want.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t dir_tab [DIR_ROWS];
        int       i;
        int       depth;
        int       target;
        bit       climbing;
        int       rnd_cnt;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        symbol         <= 8'd0;
        is_end         <= 1'b0;
        idle_phase     <= PH_SLOW_RX;
        stk_cnt        = 0;
        stk_peak       = 0;
        st_pending     = 1'b0;
        st_operand     = 8'd0;
        tmp_cnt        = 8'd0;
        is_halted      = 1'b0;
        ops_done       = 0;
        ops_at_ceiling = 0;
        err_cnt        = 0;
        beats_in       = 0;
        codes_seen     = 0;
        fault_hit      = FAULT_OVF;

        // Directed table. Typed rows: end status right after reset, after a dropped
        // store and on a non-empty stack, plain pushes (no code at all). The operator rows,
        // incl. the four-code operator right after an operator, go to the
        // predictor. Symbols on end beats walk all ones / all zeros / MSB / all but MSB.
        dir_tab[0]  = typed_row(8'hFF, 1'b1, 1'b1,
                                mk_code(ptl_pkg::KIND_END, 8'd0, 8'd0, 8'd0, 1'b1));
        dir_tab[1]  = typed_row(ptl_pkg::CH_A, 1'b0, 1'b0, '0);
        dir_tab[2]  = typed_row(ptl_pkg::CH_Z, 1'b0, 1'b0, '0);
        dir_tab[3]  = pred_row(ptl_pkg::CH_PLUS, 1'b0);
        // end drops the store of 'A', so the stack is empty again
        dir_tab[4]  = typed_row(8'h00, 1'b1, 1'b1,
                                mk_code(ptl_pkg::KIND_END, 8'd0, 8'd0, 8'd0, 1'b1));
        dir_tab[5]  = typed_row("B", 1'b0, 1'b0, '0);
        dir_tab[6]  = typed_row("C", 1'b0, 1'b0, '0);
        dir_tab[7]  = typed_row("D", 1'b0, 1'b0, '0);
        dir_tab[8]  = pred_row(ptl_pkg::CH_STAR, 1'b0);
        dir_tab[9]  = pred_row(ptl_pkg::CH_SLASH, 1'b0);
        dir_tab[10] = pred_row("M", 1'b0);
        dir_tab[11] = pred_row(ptl_pkg::CH_MINUS, 1'b0);
        dir_tab[12] = typed_row(8'h80, 1'b1, 1'b1,
                                mk_code(ptl_pkg::KIND_END, 8'd0, 8'd0, 8'd0, 1'b1));
        dir_tab[13] = typed_row("Q", 1'b0, 1'b0, '0);
        dir_tab[14] = typed_row(8'h7F, 1'b1, 1'b1,
                                mk_code(ptl_pkg::KIND_END, 8'd0, 8'd0, 8'd0, 1'b0));
        dir_tab[15] = pred_row("K", 1'b0);
        dir_tab[16] = pred_row(ptl_pkg::CH_STAR, 1'b0);
        dir_tab[17] = pred_row(ptl_pkg::CH_Z, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            send_beat(dir_tab[i].sym, dir_tab[i].end_flag, !dir_tab[i].typed);
            if (dir_tab[i].typed && dir_tab[i].has_code)
                code_due.push_back(dir_tab[i].code);
        end

        // Random part: well-formed expressions that climb to a target depth
        // (mostly shallow, now and then close to full) and then fold back
        // with operators, plus stray end beats. Faults are kept for the end
        // since they halt the block for good.
        rnd_cnt  = 0;
        target   = 4;
        climbing = 1'b1;
        while (rnd_cnt < RAND_BEATS)
        begin
            depth = stk_cnt + st_pending;
            if ($urandom_range(99) < 6)
            begin
                send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
            end
            else if (climbing)
            begin
                if (depth < target)
                begin
                    send_beat(rand_letter(), 1'b0, 1'b1);
                end
                else
                begin
                    climbing = 1'b0;
                    send_beat(rand_op(), 1'b0, 1'b1);
                end
            end
            else if (depth < 2)
            begin
                // expression folded down: start the next one
                target   = ($urandom_range(9) == 0) ? $urandom_range(63, 16)
                                                    : $urandom_range(6, 2);
                climbing = 1'b1;
                if ($urandom_range(1))
                    send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
                else
                    send_beat(rand_letter(), 1'b0, 1'b1);
            end
            else if ($urandom_range(99) < 30 && depth < STACK_DEPTH)
            begin
                send_beat(rand_letter(), 1'b0, 1'b1);
            end
            else
            begin
                send_beat(rand_op(), 1'b0, 1'b1);
            end
            rnd_cnt++;
        end

        finish_with_fault();
        in_valid <= 1'b0;

        while (code_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d beats (%0d random), %0d codes checked, %0d operators,",
                 beats_in, rnd_cnt, codes_seen, ops_done);
        $display("  stack peak %0d, temp counter %0d (%0d ops at its top), closing fault %s",
                 stk_peak, tmp_cnt, ops_at_ceiling, fault_hit.name());
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
